// File: rtl/sia_pkg.sv
// Package with widths, operation codes, pipeline record and divide-step helper.
`timescale 1ns / 1ps

package sia_pkg;

    // Operand and result width.
    localparam int WIDTH = 8;

    // Restoring-division steps done in each divide stage, and the number of stages.
    localparam int DIV_STEPS  = (WIDTH % 2 == 0) ? 2 : 1;
    localparam int DIV_STAGES = WIDTH / DIV_STEPS;

    // Operation codes carried in the request side band.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_QUO = 3'd3;
    localparam logic [OP_W-1:0] OP_REM = 3'd4;

    // Record that travels down the pipeline with each request.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             neg_q;   // quotient must be negated
        logic             neg_r;   // remainder must be negated
        logic             dz;      // divide by zero
        logic [WIDTH-1:0] res;     // add, subtract or multiply result
        logic [WIDTH-1:0] rem;     // partial remainder
        logic [WIDTH-1:0] quo;     // dividend bits shifting out, quotient bits in
        logic [WIDTH-1:0] dvs;     // divisor magnitude
    } t_pipe;

    // One restoring-division step: shift in the next dividend bit, trial subtract.
    function automatic t_pipe div_step(t_pipe p);
        t_pipe            q;
        logic [WIDTH-1:0] rem_sh;
        logic [WIDTH:0]   diff;
        q      = p;
        rem_sh = {p.rem[WIDTH-2:0], p.quo[WIDTH-1]};
        diff   = {1'b0, rem_sh} - {1'b0, p.dvs};
        if (!diff[WIDTH]) begin
            q.rem = diff[WIDTH-1:0];
        end else begin
            q.rem = rem_sh;
        end
        q.quo = {p.quo[WIDTH-2:0], ~diff[WIDTH]};
        return q;
    endfunction

endpackage

// File: rtl/signed_int8_arith_unit.sv
// Top level of the pipelined signed add, subtract, multiply and divide unit.
//
//  Channel   Dir  Signals                         Carries
//  request   in   i_s_tvalid/o_s_tready           tdata: operand_a, operand_b; tuser: operation
//  response  out  o_m_tvalid/i_m_tready           tdata: result; tuser: divide_by_zero
//
// A request can be accepted in every cycle while the response side does not stall;
// each one passes the entry stage, the divide stages of DIV_STEPS restoring
// steps each, and the sign-fix output register.
// Reset clears only the valid flags of the stages.
// Each stage holds its request while the next one is full, so a stall at the
// response side fills empty stages and then stops the request side.
`timescale 1ns / 1ps

module signed_int8_arith_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [2*sia_pkg::WIDTH-1:0]       i_s_tdata,  // operand_a, operand_b
    input  logic [sia_pkg::OP_W-1:0]          i_s_tuser,  // operation
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sia_pkg::WIDTH-1:0]         o_m_tdata,  // result
    output logic                              o_m_tuser   // divide_by_zero
);
    import sia_pkg::*;

    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [OP_W-1:0]  op;
    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;
    t_pipe            n_s0;
    t_pipe            r_s0;
    logic             r_s0_vld;
    logic             s0_rdy;

    t_pipe            div_data [DIV_STAGES+1];
    logic             div_vld  [DIV_STAGES+1];
    logic             div_rdy  [DIV_STAGES+1];

    logic             out_rdy;
    logic             r_out_vld;
    logic [WIDTH-1:0] r_out_res;
    logic             r_out_dz;
    logic [WIDTH-1:0] n_out_res;
    logic             n_out_dz;
    t_pipe            last;

    assign a  = i_s_tdata[WIDTH-1:0];
    assign b  = i_s_tdata[2*WIDTH-1:WIDTH];
    assign op = i_s_tuser;

    // Entry stage: magnitudes, signs, zero-divisor check and the non-divide results.
    always_comb begin
        mag_a = a[WIDTH-1] ? (~a + 1'b1) : a;
        mag_b = b[WIDTH-1] ? (~b + 1'b1) : b;
        n_s0       = '0;
        n_s0.op    = op;
        n_s0.neg_q = a[WIDTH-1] ^ b[WIDTH-1];
        n_s0.neg_r = a[WIDTH-1];
        n_s0.dz    = (b == '0) && (op == OP_QUO || op == OP_REM);
        n_s0.rem   = '0;
        n_s0.quo   = mag_a;
        n_s0.dvs   = mag_b;
        case (op)
            OP_ADD:  n_s0.res = a + b;
            OP_SUB:  n_s0.res = a - b;
            OP_MUL:  n_s0.res = WIDTH'(a * b);
            default: n_s0.res = '0;
        endcase
    end

    assign s0_rdy     = !r_s0_vld || div_rdy[0];
    assign o_s_tready = s0_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (s0_rdy) begin
            r_s0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_rdy && i_s_tvalid) begin
            r_s0 <= n_s0;
        end
    end

    assign div_data[0] = r_s0;
    assign div_vld[0]  = r_s0_vld;

    // Divide stages.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        sia_div_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (div_vld[g]),
            .o_rdy  (div_rdy[g]),
            .i_data (div_data[g]),
            .o_vld  (div_vld[g+1]),
            .i_rdy  (div_rdy[g+1]),
            .o_data (div_data[g+1])
        );
    end

    assign last                = div_data[DIV_STAGES];
    assign div_rdy[DIV_STAGES] = out_rdy;
    assign out_rdy             = !r_out_vld || i_m_tready;

    // Output stage: sign correction and result selection.
    always_comb begin
        n_out_dz = last.dz;
        if (last.dz) begin
            n_out_res = '0;
        end else if (last.op == OP_QUO) begin
            n_out_res = last.neg_q ? (~last.quo + 1'b1) : last.quo;
        end else if (last.op == OP_REM) begin
            n_out_res = last.neg_r ? (~last.rem + 1'b1) : last.rem;
        end else begin
            n_out_res = last.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= div_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && div_vld[DIV_STAGES]) begin
            r_out_res <= n_out_res;
            r_out_dz  <= n_out_dz;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_res;
    assign o_m_tuser  = r_out_dz;

endmodule

// File: rtl/sia_div_stage.sv
// One registered stage of the restoring divider with its own handshake.
`timescale 1ns / 1ps

module sia_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  sia_pkg::t_pipe i_data,
    output logic          o_vld,
    input  logic          i_rdy,
    output sia_pkg::t_pipe o_data
);
    import sia_pkg::*;

    logic  r_vld;
    t_pipe r_data;
    t_pipe n_data;

    // The stage takes a new request when empty or when its content moves on.
    assign o_rdy = !r_vld || i_rdy;

    // Chain of divide steps done in this stage.
    always_comb begin
        n_data = i_data;
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_data = div_step(n_data);
        end
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the pipelined signed 8-bit arithmetic unit.
`timescale 1ns / 1ps

module tb;
    import sia_pkg::*;

    // Operation codes that the unit does not define; they must give zero.
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int NUM_DIRECTED  = 24;
    localparam int NUM_RANDOM    = 1550;
    localparam int PIPE_LATENCY  = DIV_STAGES + 2;
    localparam int DRAIN_LIMIT   = 5000;

    // One row of the directed table; has_expect marks rows with a typed-in answer.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic             has_expect;
        logic [WIDTH-1:0] res;
        logic             dz;
    } t_directed_row;

    // Expected response, with the request kept for the mismatch report.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] res;
        logic             dz;
    } t_arith_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [2*WIDTH-1:0]     i_s_tdata;   // operand_a, operand_b
    logic [OP_W-1:0]        i_s_tuser;   // operation
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [WIDTH-1:0]       o_m_tdata;   // result
    logic                   o_m_tuser;   // divide_by_zero

    t_arith_result  pending_results[$];
    t_directed_row  directed_table [NUM_DIRECTED];
    int             send_idle_pct;
    int             recv_idle_pct;
    int             mismatch_count;
    int             response_count;
    int             dz_count;
    int             op_count [8];

    signed_int8_arith_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock with an 8 ns period.
    always #4 i_clk = ~i_clk;

    // Predicted response: wrapped sum, difference and product; division on
    // magnitudes with the quotient truncated toward zero and the remainder
    // carrying the dividend's sign.
    function automatic t_arith_result compute_arith(logic [OP_W-1:0] op,
                                                    logic [WIDTH-1:0] a,
                                                    logic [WIDTH-1:0] b);
        t_arith_result r;
        int sa;
        int sb;
        int mag_a;
        int mag_b;
        int quo;
        int rem;
        r.op  = op;
        r.a   = a;
        r.b   = b;
        r.res = '0;
        r.dz  = 1'b0;
        sa    = $signed(a);
        sb    = $signed(b);
        mag_a = (sa < 0) ? -sa : sa;
        mag_b = (sb < 0) ? -sb : sb;
        case (op)
            OP_ADD: r.res = a + b;
            OP_SUB: r.res = a - b;
            OP_MUL: r.res = a * b;
            OP_QUO, OP_REM: begin
                if (b == '0) begin
                    r.dz = 1'b1;
                end else begin
                    quo = mag_a / mag_b;
                    rem = mag_a % mag_b;
                    if (op == OP_QUO) begin
                        r.res = WIDTH'(((sa < 0) != (sb < 0)) ? -quo : quo);
                    end else begin
                        r.res = WIDTH'((sa < 0) ? -rem : rem);
                    end
                end
            end
            default: r.res = '0;
        endcase
        return r;
    endfunction

    // Operand with a bias toward corner values: the ends of the signed range, zero, one and minus one.
    function automatic logic [WIDTH-1:0] pick_operand();
        logic [WIDTH-1:0] v;
        v = WIDTH'($urandom_range(255));
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(4))
                0: v = 8'h80;
                1: v = 8'hFF;
                2: v = 8'h00;
                3: v = 8'h01;
                default: v = 8'h7F;
            endcase
        end
        return v;
    endfunction

    // Present one request at the falling edge and hold it until accepted.
    task automatic send_request(t_arith_result expect_rsp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= expect_rsp.op;
        i_s_tdata  <= {expect_rsp.b, expect_rsp.a};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        pending_results.push_back(expect_rsp);
    endtask

    // Response side back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge i_clk) begin
        t_arith_result exp_rsp;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response: got res=%h dz=%b",
                         $time, o_m_tdata, o_m_tuser);
                mismatch_count++;
            end else begin
                exp_rsp = pending_results.pop_front();
                response_count++;
                op_count[exp_rsp.op]++;
                if (o_m_tuser) begin
                    dz_count++;
                end
                if (o_m_tdata !== exp_rsp.res) begin
                    $display("%0t: result mismatch (op=%0d a=%h b=%h): expected %h, got %h",
                             $time, exp_rsp.op, exp_rsp.a, exp_rsp.b, exp_rsp.res,
                             o_m_tdata);
                    mismatch_count++;
                end
                if (o_m_tuser !== exp_rsp.dz) begin
                    $display("%0t: divide-by-zero mismatch (op=%0d a=%h b=%h): %s %b, got %b",
                             $time, exp_rsp.op, exp_rsp.a, exp_rsp.b, "expected",
                             exp_rsp.dz, o_m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Overall run limit.
    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    // Stimulus: reset, directed table, then three random phases.
    initial begin
        t_arith_result    req;
        logic [OP_W-1:0]  op;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        int               drain;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_ADD;
        send_idle_pct  = 36;
        recv_idle_pct  = 57;
        mismatch_count = 0;
        response_count = 0;
        dz_count       = 0;
        for (int i = 0; i < 8; i++) begin
            op_count[i] = 0;
        end

        // Edge cases; rows marked 1 carry the answer, the rest use the predictor.
        directed_table = '{
            '{OP_ADD,    8'h7F, 8'h01, 1'b1, 8'h80, 1'b0},  // positive overflow wraps
            '{OP_ADD,    8'h80, 8'h80, 1'b1, 8'h00, 1'b0},  // negative overflow wraps
            '{OP_SUB,    8'h80, 8'h01, 1'b1, 8'h7F, 1'b0},
            '{OP_SUB,    8'h7F, 8'hFF, 1'b1, 8'h80, 1'b0},
            '{OP_MUL,    8'h80, 8'hFF, 1'b1, 8'h80, 1'b0},  // -128 * -1 wraps
            '{OP_MUL,    8'h7F, 8'h7F, 1'b1, 8'h01, 1'b0},
            '{OP_MUL,    8'h80, 8'h80, 1'b1, 8'h00, 1'b0},
            '{OP_MUL,    8'hFF, 8'hFF, 1'b1, 8'h01, 1'b0},
            '{OP_QUO,    8'h80, 8'hFF, 1'b1, 8'h80, 1'b0},  // most negative by minus one
            '{OP_REM,    8'h80, 8'hFF, 1'b1, 8'h00, 1'b0},
            '{OP_QUO,    8'h7F, 8'h00, 1'b1, 8'h00, 1'b1},  // zero divisor
            '{OP_REM,    8'h80, 8'h00, 1'b1, 8'h00, 1'b1},
            '{OP_QUO,    8'h00, 8'h00, 1'b1, 8'h00, 1'b1},
            '{OP_SPARE5, 8'h7F, 8'h80, 1'b1, 8'h00, 1'b0},  // undefined codes give zero
            '{OP_SPARE6, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0},
            '{OP_SPARE7, 8'h80, 8'h7F, 1'b1, 8'h00, 1'b0},
            '{OP_QUO,    8'hF9, 8'h02, 1'b0, 8'h00, 1'b0},  // truncation toward zero
            '{OP_REM,    8'hF9, 8'h02, 1'b0, 8'h00, 1'b0},
            '{OP_QUO,    8'h07, 8'hFE, 1'b0, 8'h00, 1'b0},
            '{OP_REM,    8'h07, 8'hFE, 1'b0, 8'h00, 1'b0},
            '{OP_QUO,    8'h80, 8'h7F, 1'b0, 8'h00, 1'b0},
            '{OP_REM,    8'h80, 8'h80, 1'b0, 8'h00, 1'b0},
            '{OP_QUO,    8'h7F, 8'h80, 1'b0, 8'h00, 1'b0},
            '{OP_REM,    8'h81, 8'h03, 1'b0, 8'h00, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_table[i]) begin
            if (directed_table[i].has_expect) begin
                req.op  = directed_table[i].op;
                req.a   = directed_table[i].a;
                req.b   = directed_table[i].b;
                req.res = directed_table[i].res;
                req.dz  = directed_table[i].dz;
            end else begin
                req = compute_arith(directed_table[i].op, directed_table[i].a,
                                    directed_table[i].b);
            end
            send_request(req);
        end

        // Random requests: mostly defined operations, with divide corner cases mixed in.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 3) begin
                send_idle_pct = 57;
                recv_idle_pct = 36;
            end else if (n == 2 * NUM_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(99) < 10) begin
                op = OP_W'($urandom_range(OP_SPARE7, OP_SPARE5));
            end else begin
                op = OP_W'($urandom_range(OP_REM));
            end
            a = pick_operand();
            b = pick_operand();
            if (op == OP_QUO || op == OP_REM) begin
                case ($urandom_range(19))
                    0: b = '0;
                    1: begin
                        a = 8'h80;
                        b = 8'hFF;
                    end
                    default: ;
                endcase
            end
            send_request(compute_arith(op, a, b));
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Let the pipeline empty, then keep watching for strays.
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("Checked %0d responses: add %0d, sub %0d, mul %0d, quo %0d, rem %0d, spare %0d.",
                 response_count, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
                 op_count[OP_QUO], op_count[OP_REM],
                 op_count[OP_SPARE5] + op_count[OP_SPARE6] + op_count[OP_SPARE7]);
        $display("Zero-divisor responses: %0d; mismatches: %0d; left waiting: %0d.",
                 dz_count, mismatch_count, pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
